@@ rtl/gex_pkg.sv @@
// Shared types, register indexes and helpers for the glyph expansion unit.
`timescale 1ns / 1ps

package gex_pkg;

    localparam int MAX_GLYPH_WIDTH = 32;
    localparam int PALETTE_SIZE    = 16;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_BASE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_STRIDE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_HEIGHT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_LO_A = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_LO_B = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_HI_A = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_HI_B = 3'd6;

    typedef struct packed {
        logic        start_char;
        logic [11:0] x_pos;
        logic [11:0] y_pos;
        logic [3:0]  fg_index;
        logic [3:0]  bg_index;
        logic [5:0]  glyph_width;
        logic [7:0]  glyph_bits;
    } in_item_t;

    typedef struct packed {
        logic [31:0] write_address;
        logic [31:0] write_data;
        logic        half_write;
        logic        last_of_byte;
        logic        last_of_char;
    } out_item_t;

    // One classified bitmap byte, handed from the front to the back.
    typedef struct packed {
        logic [31:0] base;       // byte address of the byte's leftmost pixel
        logic [7:0]  bits;
        logic [3:0]  npix;       // pixels taken from this byte, 1 to 8
        logic [15:0] fg;
        logic [15:0] bg;
        logic        end_char;
    } cmd_t;

    typedef logic [3:0][63:0] palette_t;

    // Palette lookup; indexes past the palette size give black.
    function automatic logic [15:0] palette_colour(palette_t pal, logic [3:0] idx);
        logic [15:0] colour;
        colour = pal[idx[3:2]][{idx[1:0], 4'b0000} +: 16];
        if (32'(idx) >= 32'(PALETTE_SIZE)) begin
            colour = 16'h0000;
        end
        return colour;
    endfunction

endpackage

@@ rtl/gex_front.sv @@
// Front end: configuration registers, character state and byte classification.
`timescale 1ns / 1ps

module gex_front import gex_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_item,
    output logic                   cmd_valid,
    input  logic                   cmd_ready,
    output cmd_t                   cmd
);

    logic [31:0] frame_base_reg;
    logic [14:0] line_stride_reg;
    logic [5:0]  glyph_height_reg;
    palette_t    palette_reg;

    logic [31:0] row_address_reg, row_address_next;
    logic [5:0]  row_count_reg, row_count_next;
    logic [1:0]  byte_in_row_reg, byte_in_row_next;
    logic [15:0] fg_colour_reg, fg_colour_next;
    logic [15:0] bg_colour_reg, bg_colour_next;
    logic [5:0]  cell_width_reg, cell_width_next;

    logic [31:0] ra;
    logic [5:0]  rc;
    logic [1:0]  bir;
    logic [5:0]  w;
    logic [2:0]  bpr;
    logic [5:0]  remain;
    logic        end_row;
    logic        end_char;
    logic        accept;

    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;
    assign accept    = in_valid && cmd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_base_reg   <= 32'd0;
            line_stride_reg  <= 15'd1280;
            glyph_height_reg <= 6'd16;
            palette_reg      <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FRAME_BASE:   frame_base_reg   <= cfg_data[31:0];
                REG_LINE_STRIDE:  line_stride_reg  <= cfg_data[14:0];
                REG_GLYPH_HEIGHT: glyph_height_reg <= cfg_data[5:0];
                REG_PALETTE_LO_A: palette_reg[0]   <= cfg_data;
                REG_PALETTE_LO_B: palette_reg[1]   <= cfg_data;
                REG_PALETTE_HI_A: palette_reg[2]   <= cfg_data;
                REG_PALETTE_HI_B: palette_reg[3]   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        // A start byte latches a fresh cell origin, colors and width.
        ra             = row_address_reg;
        rc             = row_count_reg;
        bir            = byte_in_row_reg;
        fg_colour_next = fg_colour_reg;
        bg_colour_next = bg_colour_reg;
        cell_width_next = cell_width_reg;
        if (in_item.start_char) begin
            ra = frame_base_reg
                 + 32'(27'(line_stride_reg) * 27'(in_item.y_pos))
                 + 32'({in_item.x_pos, 1'b0});
            rc              = 6'd0;
            bir             = 2'd0;
            fg_colour_next  = palette_colour(palette_reg, in_item.fg_index);
            bg_colour_next  = palette_colour(palette_reg, in_item.bg_index);
            cell_width_next = in_item.glyph_width;
        end

        w = cell_width_next;
        if (w == 6'd0) begin
            w = 6'd1;
        end else if (32'(w) > 32'(MAX_GLYPH_WIDTH)) begin
            w = 6'(MAX_GLYPH_WIDTH);
        end
        bpr = 3'((7'(w) + 7'd7) >> 3);
        if (3'(bir) >= bpr) begin
            bir = 2'd0;
        end

        remain   = w - {1'b0, bir, 3'b000};
        end_row  = (3'(bir) + 3'd1) == bpr;
        end_char = end_row && (6'(rc + 6'd1) == glyph_height_reg);

        cmd.base     = ra + 32'({bir, 4'b0000});
        cmd.bits     = in_item.glyph_bits;
        cmd.npix     = (remain > 6'd8) ? 4'd8 : remain[3:0];
        cmd.fg       = fg_colour_next;
        cmd.bg       = bg_colour_next;
        cmd.end_char = end_char;

        if (end_row) begin
            byte_in_row_next = 2'd0;
            row_address_next = ra + 32'(line_stride_reg);
            row_count_next   = end_char ? 6'd0 : 6'(rc + 6'd1);
        end else begin
            byte_in_row_next = bir + 2'd1;
            row_address_next = ra;
            row_count_next   = rc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_address_reg <= 32'd0;
            row_count_reg   <= 6'd0;
            byte_in_row_reg <= 2'd0;
            fg_colour_reg   <= 16'd0;
            bg_colour_reg   <= 16'd0;
            cell_width_reg  <= 6'd8;
        end else if (accept) begin
            row_address_reg <= row_address_next;
            row_count_reg   <= row_count_next;
            byte_in_row_reg <= byte_in_row_next;
            fg_colour_reg   <= fg_colour_next;
            bg_colour_reg   <= bg_colour_next;
            cell_width_reg  <= cell_width_next;
        end
    end

endmodule

@@ rtl/gex_cmd_fifo.sv @@
// Two-entry command queue between the front and back ends.
`timescale 1ns / 1ps

module gex_cmd_fifo import gex_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  cmd_t wr_cmd,
    output logic rd_valid,
    input  logic rd_pop,
    output cmd_t rd_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_cmd   = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

@@ rtl/gex_back.sv @@
// Back end: splits each command into pixel-pair writes behind an output register.
`timescale 1ns / 1ps

module gex_back import gex_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cmd_valid,
    output logic      cmd_pop,
    input  cmd_t      cmd,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic [1:0] step_reg, step_next;
    logic       out_valid_reg;
    out_item_t  out_reg;
    out_item_t  wr;
    logic [2:0] pix;
    logic       left_bit;
    logic       right_bit;
    logic       half;
    logic       last;
    logic       load;

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign load      = cmd_valid && (!out_valid_reg || out_ready);
    assign cmd_pop   = load && last;

    always_comb begin
        pix       = {step_reg, 1'b0};
        left_bit  = cmd.bits[3'd7 - pix];
        right_bit = cmd.bits[3'd6 - pix];
        half      = ({1'b0, pix} + 4'd1) == cmd.npix;
        last      = ({1'b0, pix} + 4'd2) >= cmd.npix;

        wr.write_address = cmd.base + 32'({pix, 1'b0});
        wr.write_data[15:0]  = left_bit ? cmd.fg : cmd.bg;
        wr.write_data[31:16] = half ? 16'h0000 : (right_bit ? cmd.fg : cmd.bg);
        wr.half_write    = half;
        wr.last_of_byte  = last;
        wr.last_of_char  = last && cmd.end_char;

        step_next = last ? 2'd0 : step_reg + 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= wr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                step_reg      <= step_next;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/glyph_expand_rgb565_unit.sv @@
// Top level of the glyph to RGB565 expansion unit.
// Path: an accepted byte is stored in the command queue, then its writes pass through the output register to m_data.
// Throughput: one byte per cycle into the command queue while it has room; the single write
// port then drains ceil(pixels/2) writes per byte, so a full byte of eight pixels gives four writes.
// Reset: aresetn is synchronous and active low; registers return to their reset values,
// the character state restarts at an 8-pixel cell at address 0 and the queue empties.
`timescale 1ns / 1ps

module glyph_expand_rgb565_unit import gex_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration writes take effect at the edge where cfg_wr_en is high.
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Glyph byte input.
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    // Framebuffer write output.
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data
);

    // The front end resolves each byte against the character state as it is
    // accepted: it works out the byte's address, its pixel count and whether
    // it closes the character, then hands a command to the queue in the same
    // transfer. All row and cell bookkeeping therefore advances at the input
    // rate, and the input stalls while both queue entries wait for writes to drain.
    logic front_valid;
    logic front_ready;
    cmd_t front_cmd;

    // The back end reads the queue head and walks its pixel pairs, one write
    // per cycle while m_ready allows, popping the command with its last write.
    logic queue_valid;
    logic queue_pop;
    cmd_t queue_cmd;

    gex_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_data),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    // Two entries let the front take a new byte while the back is still busy
    // with the previous one, so the input stalls only when both are queued.
    gex_cmd_fifo u_cmd_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_cmd   (front_cmd),
        .rd_valid (queue_valid),
        .rd_pop   (queue_pop),
        .rd_cmd   (queue_cmd)
    );

    // The output register decouples the write port: a new write loads whenever
    // the register is empty or its transfer completes in the same cycle.
    gex_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (queue_valid),
        .cmd_pop   (queue_pop),
        .cmd       (queue_cmd),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (m_data)
    );

endmodule
